// File: rtl/core/uwb_sle_pkg.sv
// ---------------------------------------------------------------------------
// uwb_sle_pkg
// Shared types, constants and elaboration-time helpers of the signal level
// estimator.
// ---------------------------------------------------------------------------
package uwb_sle_pkg;

  // Field widths
  localparam int CNT_W   = 12;
  localparam int CIR_W   = 32;
  localparam int GAIN_W  = 3;
  localparam int CODE_W  = 5;
  localparam int CORR_W  = 15;
  localparam int LEVEL_W = 15;
  localparam int DEN_W   = 2 * CNT_W;

  // Signed offset in centi-dB: covers -(32767 + 100) .. 32767 + 7 * 600
  localparam int OFF_W = 17;

  // APB register file
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_RX_CODE      = 3'd0,
    REG_CODE_THRESH  = 3'd1,
    REG_ALPHA_PRF64  = 3'd2,
    REG_ALPHA_PRF16  = 3'd3,
    REG_LVL_OFFSET   = 3'd4
  } cfg_reg_t;

  localparam logic [CODE_W-1:0] RX_CODE_RST     = 5'd9;
  localparam logic [CODE_W-1:0] CODE_THRESH_RST = 5'd8;
  localparam logic [CORR_W-1:0] ALPHA_PRF64_RST = 15'd12070;
  localparam logic [CORR_W-1:0] ALPHA_PRF16_RST = 15'd11380;
  localparam logic [CORR_W-1:0] LVL_OFFSET_RST  = 15'd5118;

  // Level arithmetic
  localparam int PRF64_EXTRA_CDB  = 100;
  localparam int GAIN_STEP_CDB    = 600;
  localparam int LEVEL_FLOOR_CDB  = 12000;
  localparam int CDB_PER_LOG2_Q16 = 19728278;
  localparam int CDB_CONST_W      = 26;
  localparam int LOG_FRAC_BITS    = 16;
  localparam int Q_FRAC_BITS      = 32;
  localparam int MANT_W           = 32;
  localparam int TAB_VAL_W        = 17;

  // Per-item values that ride beside the log lanes
  typedef struct packed {
    logic signed [OFF_W-1:0] rssi_off;
    logic signed [OFF_W-1:0] fsl_off;
    logic                    rssi_zero;
    logic                    fsl_zero;
  } side_t;

  // Width of a Q16 log2 result for a W-bit operand padded to whole bytes
  function automatic int lg_log_w(int w);
    return $clog2(((w + 7) / 8) * 8) + TAB_VAL_W;
  endfunction

  // floor(log2(1 + i / 2^tbits) * 2^16), by repeated squaring in Q30
  function automatic logic [TAB_VAL_W-1:0] lg_tab_entry(int i, int tbits);
    logic [63:0]          y;
    logic [TAB_VAL_W-1:0] r;
    r = '0;
    y = 64'((1 << tbits) + i) << (30 - tbits);
    if (i >= (1 << tbits)) begin
      r = TAB_VAL_W'(1 << LOG_FRAC_BITS);
    end else begin
      for (int k = LOG_FRAC_BITS - 1; k >= 0; k--) begin
        y = (y * y) >> 30;
        if (y >= (64'd2 << 30)) begin
          y    = y >> 1;
          r[k] = 1'b1;
        end
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/core/uwb_sle_front.sv
// ---------------------------------------------------------------------------
// uwb_sle_front
// Front stages: amplitude squares, count squared, sum of squares and the
// per-item dB offsets with zero flags.
// ---------------------------------------------------------------------------
module uwb_sle_front #(
  parameter int  AMP_BITS = 22,
  localparam int AW       = AMP_BITS - 2,
  localparam int SUMW     = 2 * AW + 2
) (
  input  logic                                clk,
  input  logic [1:0]                          en,
  input  logic [uwb_sle_pkg::CNT_W-1:0]       accum_count,
  input  logic [AMP_BITS-1:0]                 first_amp_one,
  input  logic [AMP_BITS-1:0]                 first_amp_two,
  input  logic [AMP_BITS-1:0]                 first_amp_three,
  input  logic [uwb_sle_pkg::CIR_W-1:0]       cir_pwr,
  input  logic [uwb_sle_pkg::GAIN_W-1:0]      gain_step,
  input  logic [uwb_sle_pkg::CODE_W-1:0]      rx_code,
  input  logic [uwb_sle_pkg::CODE_W-1:0]      code_thresh,
  input  logic [uwb_sle_pkg::CORR_W-1:0]      alpha_prf64,
  input  logic [uwb_sle_pkg::CORR_W-1:0]      alpha_prf16,
  input  logic [uwb_sle_pkg::CORR_W-1:0]      lvl_offset,
  output logic [SUMW-1:0]                     sum,
  output logic [uwb_sle_pkg::DEN_W-1:0]       den,
  output logic [uwb_sle_pkg::CIR_W-1:0]       cir,
  output uwb_sle_pkg::side_t                  side
);

  localparam int OFF_W = uwb_sle_pkg::OFF_W;

  logic [AW-1:0]    a1, a2, a3;
  logic [OFF_W-1:0] gain_cdb, alpha_mag;

  logic [2*AW-1:0]                   sq1, sq2, sq3;
  logic [uwb_sle_pkg::DEN_W-1:0]     den0;
  logic [uwb_sle_pkg::CIR_W-1:0]     cir0;
  logic                              n_zero0, amp_zero0;
  logic [OFF_W-1:0]                  fsl_off0;

  // Drop the two fractional bits
  assign a1 = first_amp_one[AMP_BITS-1:2];
  assign a2 = first_amp_two[AMP_BITS-1:2];
  assign a3 = first_amp_three[AMP_BITS-1:2];

  assign gain_cdb  = OFF_W'(gain_step) * OFF_W'(uwb_sle_pkg::GAIN_STEP_CDB);
  assign alpha_mag = (rx_code > code_thresh)
                   ? OFF_W'(alpha_prf64) + OFF_W'(uwb_sle_pkg::PRF64_EXTRA_CDB)
                   : OFF_W'(alpha_prf16);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sq1       <= a1 * a1;
      sq2       <= a2 * a2;
      sq3       <= a3 * a3;
      den0      <= accum_count * accum_count;
      cir0      <= cir_pwr;
      n_zero0   <= (accum_count == '0);
      amp_zero0 <= (a1 == '0) && (a2 == '0) && (a3 == '0);
      fsl_off0  <= gain_cdb - alpha_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sum            <= SUMW'(sq1) + SUMW'(sq2) + SUMW'(sq3);
      den            <= den0;
      cir            <= cir0;
      side.fsl_off   <= fsl_off0;
      side.rssi_off  <= fsl_off0 + OFF_W'(lvl_offset);
      side.rssi_zero <= n_zero0 || (cir0 == '0);
      side.fsl_zero  <= n_zero0 || amp_zero0;
    end
  end

endmodule

// File: rtl/core/uwb_sle_log2.sv
// ---------------------------------------------------------------------------
// uwb_sle_log2
// Five-stage log2 lane in unsigned Q16: byte-wise leading one search, chunk
// select, normalize, table read, linear interpolation.
// ---------------------------------------------------------------------------
module uwb_sle_log2 #(
  parameter int  W              = 32,
  parameter int  LOG_TABLE_BITS = 8,
  localparam int LW             = uwb_sle_pkg::lg_log_w(W)
) (
  input  logic          clk,
  input  logic [4:0]    en,
  input  logic [W-1:0]  x,
  output logic [LW-1:0] lg
);

  localparam int NCH   = (W + 7) / 8;
  localparam int XW    = NCH * 8;
  localparam int PW    = $clog2(XW);
  localparam int TB    = LOG_TABLE_BITS;
  localparam int IW    = TB + 1;
  localparam int MW    = uwb_sle_pkg::MANT_W;
  localparam int REM   = MW - TB;
  localparam int TVW   = uwb_sle_pkg::TAB_VAL_W;
  localparam int TAB_N = (1 << TB) + 1;

  logic [TVW-1:0] tab [TAB_N];

  for (genvar i = 0; i < TAB_N; i++) begin : g_tab
    localparam logic [TVW-1:0] ENTRY = uwb_sle_pkg::lg_tab_entry(i, TB);
    assign tab[i] = ENTRY;
  end

  // Stage A: per-byte nonzero flag and top bit position
  logic [XW-1:0]  xp;
  logic [NCH-1:0] nz_next;
  logic [2:0]     pos_next [NCH];
  logic [XW-1:0]  x0;
  logic [NCH-1:0] nz0;
  logic [2:0]     pos0 [NCH];

  assign xp = XW'(x);

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      nz_next[c]  = |xp[c*8 +: 8];
      pos_next[c] = '0;
      for (int j = 0; j < 8; j++) begin
        if (xp[c*8 + j]) pos_next[c] = 3'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x0  <= xp;
      nz0 <= nz_next;
      for (int c = 0; c < NCH; c++) pos0[c] <= pos_next[c];
    end
  end

  // Stage B: highest nonzero byte gives the leading one position
  logic [PW-1:0] p_next;
  logic [XW-1:0] x1;
  logic [PW-1:0] p1;

  always_comb begin
    p_next = '0;
    for (int c = 0; c < NCH; c++) begin
      if (nz0[c]) p_next = PW'(c * 8) | PW'(pos0[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      x1 <= x0;
      p1 <= p_next;
    end
  end

  // Stage C: the bits below the leading one form the mantissa
  logic [XW+MW-1:0] xsh;
  logic [MW-1:0]    frac;
  logic [TB-1:0]    idx2;
  logic [REM-1:0]   rem2;
  logic [PW-1:0]    p2;

  assign xsh  = {x1, MW'(0)} >> p1;
  assign frac = xsh[MW-1:0];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      idx2 <= frac[MW-1 -: TB];
      rem2 <= frac[REM-1:0];
      p2   <= p1;
    end
  end

  // Stage D: bracketing table entries
  logic [TVW-1:0] lo, hi;
  logic [TVW-1:0] lo3, diff3;
  logic [REM-1:0] rem3;
  logic [PW-1:0]  p3;

  assign lo = tab[IW'(idx2)];
  assign hi = tab[IW'(idx2) + IW'(1)];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      lo3   <= lo;
      diff3 <= hi - lo;
      rem3  <= rem2;
      p3    <= p2;
    end
  end

  // Stage E: interpolate and add the integer part
  logic [TVW+REM-1:0] prod;
  logic [TVW-1:0]     interp;

  assign prod   = diff3 * rem3;
  assign interp = prod[TVW+REM-1:REM];

  always_ff @(posedge clk) begin
    if (en[4]) begin
      lg <= LW'({p3, uwb_sle_pkg::LOG_FRAC_BITS'(0)}) + LW'(lo3) + LW'(interp);
    end
  end

endmodule

// File: rtl/core/uwb_sle_level.sv
// ---------------------------------------------------------------------------
// uwb_sle_level
// Four-stage level lane: log ratio, scale to centi-dB in Q32, add offset,
// range check and truncate toward zero.
// ---------------------------------------------------------------------------
module uwb_sle_level #(
  parameter int LNW = 23,
  parameter int LDW = 22
) (
  input  logic                                       clk,
  input  logic [3:0]                                 en,
  input  logic [LNW-1:0]                             lnum,
  input  logic [LDW-1:0]                             lden,
  input  logic                                       zero,
  input  logic signed [uwb_sle_pkg::OFF_W-1:0]       off,
  output logic signed [uwb_sle_pkg::LEVEL_W-1:0]     level
);

  localparam int OFF_W = uwb_sle_pkg::OFF_W;
  localparam int QF    = uwb_sle_pkg::Q_FRAC_BITS;
  localparam int LVW   = uwb_sle_pkg::LEVEL_W;
  localparam int DW    = ((LNW > LDW) ? LNW : LDW) + 1;
  localparam int MW    = DW + uwb_sle_pkg::CDB_CONST_W;
  localparam int QW    = (MW + 1 > OFF_W + QF + 1) ? MW + 1 : OFF_W + QF + 1;

  localparam logic signed [uwb_sle_pkg::CDB_CONST_W-1:0] CDB_S =
    uwb_sle_pkg::CDB_CONST_W'(uwb_sle_pkg::CDB_PER_LOG2_Q16);
  localparam logic signed [QW-1:0] QMIN =
    -(QW'(uwb_sle_pkg::LEVEL_FLOOR_CDB) <<< QF);

  logic signed [DW-1:0]    d0;
  logic                    zero0, zero1, zero2;
  logic signed [OFF_W-1:0] off0, off1;
  logic signed [MW-1:0]    prod1;
  logic signed [QW-1:0]    q2;
  logic                    q_pos, q_low;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d0    <= DW'(lnum) - DW'(lden);
      zero0 <= zero;
      off0  <= off;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      prod1 <= d0 * CDB_S;
      zero1 <= zero0;
      off1  <= off0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      q2    <= QW'(prod1) + (QW'(off1) <<< QF);
      zero2 <= zero1;
    end
  end

  assign q_pos = !q2[QW-1] && (q2 != '0);
  assign q_low = (q2 < QMIN);

  // Round toward zero: bump the integer part when any fraction bit is set
  always_ff @(posedge clk) begin
    if (en[3]) begin
      if (zero2 || q_pos || q_low) begin
        level <= '0;
      end else begin
        level <= q2[QF +: LVW] + LVW'(q2[QF-1:0] != '0);
      end
    end
  end

endmodule

// File: rtl/core/uwb_signal_level_estimator.sv
// ---------------------------------------------------------------------------
// uwb_signal_level_estimator
// Received level and first path level, in centi-dB, from one channel
// diagnostic set.
// ---------------------------------------------------------------------------
// Usage: one diagnostic set enters on the s_t* stream (accum_count, three
// first path amplitudes, cir_pwr, gain_step packed in s_tdata) and one
// result leaves on the m_t* stream (rssi_centi_db, fsl_centi_db in m_tdata).
// The APB port holds the receive code, PRF corrections, code threshold and level offset;
// write it only while no item is in flight.
// Pipeline: eleven register stages: front squares (2), log2 lanes (5),
// level lanes (4). Throughput: one item per clock unless the output is
// stalled with every stage full.
// Every stage carries a valid bit; a stage loads whenever it or some stage
// after it is empty, so bubbles close up while the output is stalled and
// s_tready falls only when all eleven stages hold an item and m_tready is low.
// Reset clears the valid bits and loads the register defaults; no sweep of
// any table follows.
// ---------------------------------------------------------------------------
module uwb_signal_level_estimator #(
  parameter int  AMP_BITS       = 22,
  parameter int  LOG_TABLE_BITS = 8,
  localparam int IN_W  = ((uwb_sle_pkg::CNT_W + 3 * AMP_BITS + uwb_sle_pkg::CIR_W
                          + uwb_sle_pkg::GAIN_W + 7) / 8) * 8,
  localparam int OUT_W = ((2 * uwb_sle_pkg::LEVEL_W + 7) / 8) * 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // accum_count, first_amp_one, first_amp_two, first_amp_three, cir_pwr,
  // gain_step (lowest bits first)
  input  logic [IN_W-1:0]                       s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // rssi_centi_db, fsl_centi_db (lowest bits first)
  output logic [OUT_W-1:0]                      m_tdata,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [uwb_sle_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [uwb_sle_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [uwb_sle_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                  pready
);

  localparam int CNT_W   = uwb_sle_pkg::CNT_W;
  localparam int CIR_W   = uwb_sle_pkg::CIR_W;
  localparam int CODE_W  = uwb_sle_pkg::CODE_W;
  localparam int CORR_W  = uwb_sle_pkg::CORR_W;
  localparam int LEVEL_W = uwb_sle_pkg::LEVEL_W;
  localparam int DATA_W  = uwb_sle_pkg::CFG_DATA_W;
  localparam int SUMW    = 2 * (AMP_BITS - 2) + 2;

  localparam int FRONT_ST = 2;
  localparam int LOG_ST   = 5;
  localparam int LEVEL_ST = 4;
  localparam int NST      = FRONT_ST + LOG_ST + LEVEL_ST;
  localparam int LOG_LO   = FRONT_ST;
  localparam int LEVEL_LO = FRONT_ST + LOG_ST;

  localparam int LW_CIR = uwb_sle_pkg::lg_log_w(CIR_W);
  localparam int LW_DEN = uwb_sle_pkg::lg_log_w(uwb_sle_pkg::DEN_W);
  localparam int LW_SUM = uwb_sle_pkg::lg_log_w(SUMW);

  // Field offsets in s_tdata
  localparam int AMP1_LSB = CNT_W;
  localparam int AMP2_LSB = AMP1_LSB + AMP_BITS;
  localparam int AMP3_LSB = AMP2_LSB + AMP_BITS;
  localparam int CIR_LSB  = AMP3_LSB + AMP_BITS;
  localparam int GAIN_LSB = CIR_LSB + CIR_W;

  // ---- configuration registers ----
  logic [CODE_W-1:0] rx_code, code_thresh;
  logic [CORR_W-1:0] alpha_prf64, alpha_prf16, lvl_offset;
  logic              cfg_wr;
  uwb_sle_pkg::cfg_reg_t cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = uwb_sle_pkg::cfg_reg_t'(paddr[uwb_sle_pkg::CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_code     <= uwb_sle_pkg::RX_CODE_RST;
      code_thresh <= uwb_sle_pkg::CODE_THRESH_RST;
      alpha_prf64 <= uwb_sle_pkg::ALPHA_PRF64_RST;
      alpha_prf16 <= uwb_sle_pkg::ALPHA_PRF16_RST;
      lvl_offset  <= uwb_sle_pkg::LVL_OFFSET_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        uwb_sle_pkg::REG_RX_CODE:     rx_code     <= pwdata[CODE_W-1:0];
        uwb_sle_pkg::REG_CODE_THRESH: code_thresh <= pwdata[CODE_W-1:0];
        uwb_sle_pkg::REG_ALPHA_PRF64: alpha_prf64 <= pwdata[CORR_W-1:0];
        uwb_sle_pkg::REG_ALPHA_PRF16: alpha_prf16 <= pwdata[CORR_W-1:0];
        uwb_sle_pkg::REG_LVL_OFFSET:  lvl_offset  <= pwdata[CORR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      uwb_sle_pkg::REG_RX_CODE:     prdata = DATA_W'(rx_code);
      uwb_sle_pkg::REG_CODE_THRESH: prdata = DATA_W'(code_thresh);
      uwb_sle_pkg::REG_ALPHA_PRF64: prdata = DATA_W'(alpha_prf64);
      uwb_sle_pkg::REG_ALPHA_PRF16: prdata = DATA_W'(alpha_prf16);
      uwb_sle_pkg::REG_LVL_OFFSET:  prdata = DATA_W'(lvl_offset);
      default:                      prdata = '0;
    endcase
  end

  // ---- pipeline control ----
  logic [NST-1:0] vld, rdy;

  // A stage may load unless it and every stage after it are full and stalled
  for (genvar k = 0; k < NST; k++) begin : g_rdy
    assign rdy[k] = m_tready || !(&vld[NST-1:k]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= s_tvalid;
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign s_tready = rdy[0];
  assign m_tvalid = vld[NST-1];

  // ---- front ----
  logic [SUMW-1:0]               sum;
  logic [uwb_sle_pkg::DEN_W-1:0] den;
  logic [CIR_W-1:0]              cir;
  uwb_sle_pkg::side_t            side_f;
  uwb_sle_pkg::side_t            side_q [LOG_ST];

  uwb_sle_front #(
    .AMP_BITS (AMP_BITS)
  ) u_front (
    .clk             (clk),
    .en              (rdy[FRONT_ST-1:0]),
    .accum_count     (s_tdata[CNT_W-1:0]),
    .first_amp_one   (s_tdata[AMP1_LSB +: AMP_BITS]),
    .first_amp_two   (s_tdata[AMP2_LSB +: AMP_BITS]),
    .first_amp_three (s_tdata[AMP3_LSB +: AMP_BITS]),
    .cir_pwr         (s_tdata[CIR_LSB +: CIR_W]),
    .gain_step       (s_tdata[GAIN_LSB +: uwb_sle_pkg::GAIN_W]),
    .rx_code         (rx_code),
    .code_thresh     (code_thresh),
    .alpha_prf64     (alpha_prf64),
    .alpha_prf16     (alpha_prf16),
    .lvl_offset      (lvl_offset),
    .sum             (sum),
    .den             (den),
    .cir             (cir),
    .side            (side_f)
  );

  // ---- log2 lanes; offsets and zero flags ride alongside ----
  logic [LW_CIR-1:0] lg_cir;
  logic [LW_DEN-1:0] lg_den;
  logic [LW_SUM-1:0] lg_sum;

  uwb_sle_log2 #(
    .W (CIR_W), .LOG_TABLE_BITS (LOG_TABLE_BITS)
  ) u_log_cir (
    .clk (clk), .en (rdy[LEVEL_LO-1:LOG_LO]), .x (cir), .lg (lg_cir)
  );

  uwb_sle_log2 #(
    .W (uwb_sle_pkg::DEN_W), .LOG_TABLE_BITS (LOG_TABLE_BITS)
  ) u_log_den (
    .clk (clk), .en (rdy[LEVEL_LO-1:LOG_LO]), .x (den), .lg (lg_den)
  );

  uwb_sle_log2 #(
    .W (SUMW), .LOG_TABLE_BITS (LOG_TABLE_BITS)
  ) u_log_sum (
    .clk (clk), .en (rdy[LEVEL_LO-1:LOG_LO]), .x (sum), .lg (lg_sum)
  );

  always_ff @(posedge clk) begin
    if (rdy[LOG_LO]) side_q[0] <= side_f;
    for (int j = 1; j < LOG_ST; j++) begin
      if (rdy[LOG_LO + j]) side_q[j] <= side_q[j-1];
    end
  end

  // ---- level lanes ----
  logic signed [LEVEL_W-1:0] rssi_lvl, fsl_lvl;

  uwb_sle_level #(
    .LNW (LW_CIR), .LDW (LW_DEN)
  ) u_level_rssi (
    .clk   (clk),
    .en    (rdy[NST-1:LEVEL_LO]),
    .lnum  (lg_cir),
    .lden  (lg_den),
    .zero  (side_q[LOG_ST-1].rssi_zero),
    .off   (side_q[LOG_ST-1].rssi_off),
    .level (rssi_lvl)
  );

  uwb_sle_level #(
    .LNW (LW_SUM), .LDW (LW_DEN)
  ) u_level_fsl (
    .clk   (clk),
    .en    (rdy[NST-1:LEVEL_LO]),
    .lnum  (lg_sum),
    .lden  (lg_den),
    .zero  (side_q[LOG_ST-1].fsl_zero),
    .off   (side_q[LOG_ST-1].fsl_off),
    .level (fsl_lvl)
  );

  assign m_tdata = {(OUT_W - 2 * LEVEL_W)'(0), fsl_lvl, rssi_lvl};

  // ---- assertions ----
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled while the output side can move");

  a_rssi_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (rssi_lvl <= 0 && rssi_lvl >= -uwb_sle_pkg::LEVEL_FLOOR_CDB))
    else $error("received level outside its range");

  a_fsl_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (fsl_lvl <= 0 && fsl_lvl >= -uwb_sle_pkg::LEVEL_FLOOR_CDB))
    else $error("first path level outside its range");

endmodule

// File: verif/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the signal level estimator: a software-side level
// predictor, with its own log2 table and register copy, scores every result
// on the master stream against the diagnostic set that produced it, across
// several register settings and random backpressure on both streams.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int     CNT_W            = uwb_sle_pkg::CNT_W;
  localparam int     CIR_W            = uwb_sle_pkg::CIR_W;
  localparam int     GAIN_W           = uwb_sle_pkg::GAIN_W;
  localparam int     CODE_W           = uwb_sle_pkg::CODE_W;
  localparam int     CORR_W           = uwb_sle_pkg::CORR_W;
  localparam int     LEVEL_W          = uwb_sle_pkg::LEVEL_W;
  localparam int     CFG_ADDR_W       = uwb_sle_pkg::CFG_ADDR_W;
  localparam int     CFG_DATA_W       = uwb_sle_pkg::CFG_DATA_W;
  localparam int     CDB_PER_LOG2_Q16 = uwb_sle_pkg::CDB_PER_LOG2_Q16;
  localparam int     LEVEL_FLOOR_CDB  = uwb_sle_pkg::LEVEL_FLOOR_CDB;
  localparam int     GAIN_STEP_CDB    = uwb_sle_pkg::GAIN_STEP_CDB;
  localparam int     PRF64_EXTRA_CDB  = uwb_sle_pkg::PRF64_EXTRA_CDB;
  localparam int     AMP_W       = 22;
  localparam int     LUT_BITS    = 8;
  localparam int     IN_USED     = CNT_W + 3 * AMP_W + CIR_W + GAIN_W;
  localparam int     IN_W        = ((IN_USED + 7) / 8) * 8;
  localparam int     OUT_W       = ((2 * LEVEL_W + 7) / 8) * 8;
  localparam int     PIPE_PAD    = 16;
  localparam int     STALL_LIMIT = 4000;
  localparam longint Q32_UNIT    = longint'(1) <<< 32;

  // One diagnostic set, laid out as on s_tdata (last field, cnt, lowest)
  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [CIR_W-1:0]  cir;
    logic [AMP_W-1:0]  amp3;
    logic [AMP_W-1:0]  amp2;
    logic [AMP_W-1:0]  amp1;
    logic [CNT_W-1:0]  cnt;
  } diag_t;

  typedef struct {
    logic signed [LEVEL_W-1:0] rssi;
    logic signed [LEVEL_W-1:0] fsl;
  } level_pair_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // accum_count, first_amp_one, first_amp_two, first_amp_three, cir_pwr,
  // gain_step (lowest bits first)
  logic [IN_W-1:0]       s_tdata  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // rssi_centi_db, fsl_centi_db (lowest bits first)
  logic [OUT_W-1:0]      m_tdata;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr    = '0;
  logic [CFG_DATA_W-1:0] pwdata   = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Register copy used by the predictor
  logic [CODE_W-1:0] cfg_rx_code   = uwb_sle_pkg::RX_CODE_RST;
  logic [CODE_W-1:0] cfg_threshold = uwb_sle_pkg::CODE_THRESH_RST;
  logic [CORR_W-1:0] cfg_alpha64   = uwb_sle_pkg::ALPHA_PRF64_RST;
  logic [CORR_W-1:0] cfg_alpha16   = uwb_sle_pkg::ALPHA_PRF16_RST;
  logic [CORR_W-1:0] cfg_log_const = uwb_sle_pkg::LVL_OFFSET_RST;

  logic [16:0]  log_frac_lut [0:(1 << LUT_BITS)];
  level_pair_t  level_q [$];
  int           tx_idle_pct  = 0;
  int           rx_idle_pct  = 0;
  int           fail_count   = 0;
  int           sets_sent    = 0;
  int           levels_seen  = 0;
  int           settings_run = 1;
  int           stall_cycles = 0;

  uwb_signal_level_estimator #(
    .AMP_BITS       (AMP_W),
    .LOG_TABLE_BITS (LUT_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #6 clk = ~clk;

  // ------------------------------------------------------------------
  // Level predictor
  // ------------------------------------------------------------------

  // floor(log2(1 + i/2^LUT_BITS) * 2^16) by squaring a Q30 value bit by bit
  function automatic logic [16:0] lut_point(input int i);
    logic [63:0] sq;
    logic [16:0] bits;
    if (i >= (1 << LUT_BITS)) return 17'd65536;
    sq   = 64'((1 << LUT_BITS) + i) << (30 - LUT_BITS);
    bits = '0;
    for (int k = 15; k >= 0; k--) begin
      sq = (sq * sq) >> 30;
      if (sq >= (64'd1 << 31)) begin
        sq      = sq >> 1;
        bits[k] = 1'b1;
      end
    end
    return bits;
  endfunction

  // log2(x) in unsigned Q16, x > 0
  function automatic logic [31:0] lg2_fix(input logic [63:0] x);
    int          msb;
    logic [63:0] norm;
    logic [31:0] frac;
    int          idx;
    logic [63:0] rem;
    logic [63:0] lo;
    logic [63:0] hi;
    msb = 0;
    for (int b = 0; b < 64; b++) if (x[b]) msb = b;
    norm = (msb >= 32) ? (x >> (msb - 32)) : (x << (32 - msb));
    frac = norm[31:0];
    idx  = int'(frac >> (32 - LUT_BITS));
    rem  = 64'(frac & ((32'd1 << (32 - LUT_BITS)) - 1));
    lo   = 64'(log_frac_lut[idx]);
    hi   = 64'(log_frac_lut[idx + 1]);
    return 32'((64'(msb) << 16) + lo + (((hi - lo) * rem) >> (32 - LUT_BITS)));
  endfunction

  function automatic logic signed [LEVEL_W-1:0] level_cdb(input logic [63:0] num,
                                                          input logic [63:0] den,
                                                          input longint off);
    longint      d;
    longint      q;
    logic [63:0] mag;
    if (num == 0 || den == 0) return '0;
    d = longint'({32'd0, lg2_fix(num)}) - longint'({32'd0, lg2_fix(den)});
    q = d * longint'(CDB_PER_LOG2_Q16) + off * Q32_UNIT;
    if (q > 0 || q < -longint'(LEVEL_FLOOR_CDB) * Q32_UNIT) return '0;
    // truncate toward zero
    mag = $unsigned(-q) >> 32;
    return LEVEL_W'(-longint'(mag));
  endfunction

  function automatic level_pair_t predict_levels(input diag_t d);
    logic [63:0] a1;
    logic [63:0] a2;
    logic [63:0] a3;
    logic [63:0] den;
    logic [63:0] pwr_sum;
    longint      alpha;
    longint      gain_cdb;
    level_pair_t r;
    a1       = 64'(d.amp1 >> 2);
    a2       = 64'(d.amp2 >> 2);
    a3       = 64'(d.amp3 >> 2);
    den      = 64'(d.cnt) * 64'(d.cnt);
    pwr_sum  = a1 * a1 + a2 * a2 + a3 * a3;
    gain_cdb = longint'(d.gain) * GAIN_STEP_CDB;
    alpha    = (cfg_rx_code > cfg_threshold) ?
               -(longint'(cfg_alpha64) + PRF64_EXTRA_CDB) : -longint'(cfg_alpha16);
    r.rssi = level_cdb(64'(d.cir), den, alpha + longint'(cfg_log_const) + gain_cdb);
    r.fsl  = level_cdb(pwr_sum, den, alpha + gain_cdb);
    return r;
  endfunction

  // ------------------------------------------------------------------
  // Receiver, scoreboard and watchdog
  // ------------------------------------------------------------------

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    level_pair_t want;
    logic signed [LEVEL_W-1:0] got_rssi;
    logic signed [LEVEL_W-1:0] got_fsl;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        levels_seen++;
        got_rssi = m_tdata[LEVEL_W-1:0];
        got_fsl  = m_tdata[2*LEVEL_W-1:LEVEL_W];
        if (level_q.size() == 0) begin
          $error("unexpected result: rssi_centi_db %0d, fsl_centi_db %0d",
                 got_rssi, got_fsl);
          fail_count++;
        end else begin
          want = level_q.pop_front();
          if (got_rssi !== want.rssi) begin
            $error("rssi_centi_db: expected %0d, got %0d", want.rssi, got_rssi);
            fail_count++;
          end
          if (got_fsl !== want.fsl) begin
            $error("fsl_centi_db: expected %0d, got %0d", want.fsl, got_fsl);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        sets_sent++;
        level_q.push_back(predict_levels(diag_t'(s_tdata[IN_USED-1:0])));
      end
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------

  task automatic send_diag(input diag_t d);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata  <= {{(IN_W - IN_USED){1'b0}}, d};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Hold the sender until every result is back, then let the pipe settle
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (level_q.size() != 0) @(posedge clk);
    repeat (PIPE_PAD) @(posedge clk);
  endtask

  task automatic apb_xfer(input uwb_sle_pkg::cfg_reg_t r, input bit wr,
                          input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= CFG_ADDR_W'(int'(r) * 4);
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    rdata = prdata;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input uwb_sle_pkg::cfg_reg_t r, input logic [31:0] want);
    logic [31:0] got;
    apb_xfer(r, 1'b0, '0, got);
    if (got !== want) begin
      $error("%s readback: expected %0d, got %0d", r.name(), want, got);
      fail_count++;
    end
  endtask

  // Write all five registers (block idle), mirror them and read them back
  task automatic program_regs(input int rx, input int thr, input int a64,
                              input int a16, input int lc);
    logic [31:0] unused;
    drain_results();
    apb_xfer(uwb_sle_pkg::REG_RX_CODE,     1'b1, 32'(rx),  unused);
    apb_xfer(uwb_sle_pkg::REG_CODE_THRESH, 1'b1, 32'(thr), unused);
    apb_xfer(uwb_sle_pkg::REG_ALPHA_PRF64, 1'b1, 32'(a64), unused);
    apb_xfer(uwb_sle_pkg::REG_ALPHA_PRF16, 1'b1, 32'(a16), unused);
    apb_xfer(uwb_sle_pkg::REG_LVL_OFFSET,  1'b1, 32'(lc),  unused);
    cfg_rx_code   = CODE_W'(rx);
    cfg_threshold = CODE_W'(thr);
    cfg_alpha64   = CORR_W'(a64);
    cfg_alpha16   = CORR_W'(a16);
    cfg_log_const = CORR_W'(lc);
    check_reg(uwb_sle_pkg::REG_RX_CODE,     32'(cfg_rx_code));
    check_reg(uwb_sle_pkg::REG_CODE_THRESH, 32'(cfg_threshold));
    check_reg(uwb_sle_pkg::REG_ALPHA_PRF64, 32'(cfg_alpha64));
    check_reg(uwb_sle_pkg::REG_ALPHA_PRF16, 32'(cfg_alpha16));
    check_reg(uwb_sle_pkg::REG_LVL_OFFSET,  32'(cfg_log_const));
    settings_run++;
  endtask

  function automatic diag_t mk_diag(input int unsigned cnt, input int unsigned a1,
                                    input int unsigned a2, input int unsigned a3,
                                    input int unsigned cir, input int unsigned g);
    diag_t d;
    d.cnt  = CNT_W'(cnt);
    d.amp1 = AMP_W'(a1);
    d.amp2 = AMP_W'(a2);
    d.amp3 = AMP_W'(a3);
    d.cir  = CIR_W'(cir);
    d.gain = GAIN_W'(g);
    return d;
  endfunction

  // Uniform now and then, otherwise a random bit length so levels spread
  // over the whole dB range instead of piling up at the top
  function automatic logic [31:0] rand_field(input int w);
    logic [31:0] v;
    int          span;
    v    = $urandom;
    span = ($urandom_range(3) == 0) ? w : $urandom_range(w, 0);
    if (span < 32) v = v & ((32'd1 << span) - 1);
    return v;
  endfunction

  function automatic diag_t rand_diag();
    return mk_diag(rand_field(CNT_W), rand_field(AMP_W), rand_field(AMP_W),
                   rand_field(AMP_W), rand_field(CIR_W), $urandom_range(7));
  endfunction

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_diag(rand_diag());
  endtask

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  task automatic test_reset_values();
    check_reg(uwb_sle_pkg::REG_RX_CODE,     32'(uwb_sle_pkg::RX_CODE_RST));
    check_reg(uwb_sle_pkg::REG_CODE_THRESH, 32'(uwb_sle_pkg::CODE_THRESH_RST));
    check_reg(uwb_sle_pkg::REG_ALPHA_PRF64, 32'(uwb_sle_pkg::ALPHA_PRF64_RST));
    check_reg(uwb_sle_pkg::REG_ALPHA_PRF16, 32'(uwb_sle_pkg::ALPHA_PRF16_RST));
    check_reg(uwb_sle_pkg::REG_LVL_OFFSET,  32'(uwb_sle_pkg::LVL_OFFSET_RST));
  endtask

  task automatic test_directed_sets();
    int unsigned amp_max;
    amp_max = (1 << AMP_W) - 1;
    // zero accumulation count
    send_diag(mk_diag(0, amp_max, amp_max, amp_max, 32'hFFFF_FFFF, 7));
    // zero power and zero amplitudes
    send_diag(mk_diag(1, 0, 0, 0, 0, 0));
    // amplitudes below one whole step square to zero
    send_diag(mk_diag(1, 3, 3, 3, 1, 0));
    send_diag(mk_diag(4095, amp_max, amp_max, amp_max, 32'hFFFF_FFFF, 7));
    // above 0 dB on both levels
    send_diag(mk_diag(1, amp_max, amp_max, amp_max, 32'hFFFF_FFFF, 0));
    // below the floor on both levels
    send_diag(mk_diag(4095, 4, 0, 0, 1, 0));
    // one amplitude point at a time
    send_diag(mk_diag(64, amp_max, 0, 0, 32'h0001_0000, 3));
    send_diag(mk_diag(64, 0, amp_max, 0, 32'h0010_0000, 4));
    send_diag(mk_diag(64, 0, 0, amp_max, 32'h0100_0000, 5));
    // walk the gain step
    for (int g = 0; g < 8; g++) send_diag(mk_diag(1024, 40000, 40000, 40000, 1 << 30, g));
    send_diag(mk_diag(4095, 22'h2AAAAA, 22'h155555, 22'h2AAAAA, 32'hAAAA_5555, 2));
    send_diag(mk_diag(2730, 22'h155555, 22'h2AAAAA, 22'h155555, 32'h5555_AAAA, 5));
    // exact power-of-two ratio
    send_diag(mk_diag(2048, 8192, 0, 0, 1 << 22, 1));
  endtask

  task automatic test_default_random();
    send_random(150);
  endtask

  task automatic test_prf_select();
    program_regs(0, 31, 0, 0, 0);
    send_random(40);
    program_regs(31, 0, 20000, 20000, 20000);
    send_random(40);
    program_regs(16, 16, 0, 20000, 20000);
    send_random(40);
    program_regs(17, 16, 0, 0, 0);
    send_random(40);
    // corrections beyond their nominal range are used as written
    program_regs(31, 30, 32767, 32767, 32767);
    send_random(40);
    program_regs(0, 0, 5000, 5000, 5000);
    send_random(40);
  endtask

  task automatic test_random_settings();
    for (int s = 0; s < 5; s++) begin
      program_regs($urandom_range(31), $urandom_range(31), $urandom_range(20000),
                   $urandom_range(20000), $urandom_range(20000));
      send_random(25);
      drain_results();
      send_random(25);
    end
  endtask

  initial begin
    for (int i = 0; i <= (1 << LUT_BITS); i++) log_frac_lut[i] = lut_point(i);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 30;
    rx_idle_pct = 78;
    test_reset_values();
    test_directed_sets();
    test_default_random();

    tx_idle_pct = 78;
    rx_idle_pct = 30;
    test_prf_select();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_settings();

    drain_results();
    $display("Sent %0d diagnostic sets under %0d register settings, checked %0d results",
             sets_sent, settings_run, levels_seen);
    $display("Covered zero count, zero power, range clipping, both PRF modes, all gain steps");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: uwb_signal_level_estimator.f
rtl/core/uwb_sle_pkg.sv
rtl/core/uwb_sle_front.sv
rtl/core/uwb_sle_log2.sv
rtl/core/uwb_sle_level.sv
rtl/core/uwb_signal_level_estimator.sv
verif/tb_top.sv
